@@ rtl/core/ile_pkg.sv @@
// Shared types and constants of the indexed list engine.
package ile_pkg;

	localparam int POS_W  = 9;
	localparam int DATA_W = 32;
	localparam int CNT_W  = 9;

	localparam logic [1:0] REQ_APPEND = 2'd0;
	localparam logic [1:0] REQ_INSERT = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;
	localparam logic [1:0] REQ_READ   = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BOUNDS = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	typedef struct packed {
		logic [1:0]              req_type;
		logic [POS_W-1:0]        position;
		logic signed [DATA_W-1:0] data_in;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] data_out;
		logic [CNT_W-1:0]         item_count;
		logic                     is_empty;
	} rsp_t;

	typedef enum logic [2:0] {
		ADDR_HOLD,
		ADDR_LAST,
		ADDR_POS,
		ADDR_INC,
		ADDR_DEC
	} addr_op_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_DATA_END,
		WR_DATA_POS,
		WR_UP,
		WR_DOWN
	} wr_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	typedef enum logic [1:0] {
		RES_HOLD,
		RES_CLR,
		RES_TAKE
	} res_op_t;

	typedef struct packed {
		logic       req_load;
		addr_op_t   addr_op;
		logic       rd_en;
		wr_op_t     wr_op;
		cnt_op_t    cnt_op;
		res_op_t    res_op;
		logic       st_set;
		logic [1:0] st_code;
		logic       out_load;
	} ile_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       full;
		logic       empty;
		logic       pos_gt_count;
		logic       pos_ge_count;
		logic       addr_at_pos;
		logic       addr_at_last;
		logic       rd_valid_s1;
		logic       rd_at_pos_s1;
		logic       out_free;
	} ile_status_t;

endpackage

@@ rtl/core/ile_datapath.sv @@
// Datapath of the indexed list engine: entry store, count, address walk and result register.
module ile_datapath #(
	parameter int CAPACITY = 256,
	parameter int CW       = 9,
	parameter int AW       = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ile_pkg::req_t        req,
	input  logic                 rsp_stall,
	output logic                 rsp_valid,
	output ile_pkg::rsp_t        rsp,
	input  ile_pkg::ile_cmd_t    cmd,
	output ile_pkg::ile_status_t sts
);

	localparam int MW = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W;

	logic [ile_pkg::DATA_W-1:0] mem [CAPACITY];

	ile_pkg::req_t              req_q;
	logic [CW-1:0]              count_q;
	logic [AW-1:0]              addr_q;
	logic [AW-1:0]              raddr_s1;
	logic                       rd_valid_s1;
	logic [ile_pkg::DATA_W-1:0] rdata_s1;
	logic [ile_pkg::DATA_W-1:0] res_data_q;
	logic [1:0]                 status_q;
	ile_pkg::rsp_t              rsp_q;
	logic                       rsp_valid_q;

	logic [MW-1:0]              pos_x;
	logic [MW-1:0]              cnt_x;
	logic [MW-1:0]              addr_x;
	logic [MW-1:0]              raddr_x;
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	logic [ile_pkg::DATA_W-1:0] wr_data;

	assign pos_x   = MW'(req_q.position);
	assign cnt_x   = MW'(count_q);
	assign addr_x  = MW'(addr_q);
	assign raddr_x = MW'(raddr_s1);

	assign sts.kind         = req_q.req_type;
	assign sts.full         = (count_q == CW'(CAPACITY));
	assign sts.empty        = (count_q == '0);
	assign sts.pos_gt_count = (pos_x > cnt_x);
	assign sts.pos_ge_count = (pos_x >= cnt_x);
	assign sts.addr_at_pos  = (addr_x == pos_x);
	assign sts.addr_at_last = (addr_x == (cnt_x - MW'(1)));
	assign sts.rd_valid_s1  = rd_valid_s1;
	assign sts.rd_at_pos_s1 = (raddr_x == pos_x);
	assign sts.out_free     = !rsp_valid_q || !rsp_stall;

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = raddr_s1;
		wr_data = rdata_s1;
		case (cmd.wr_op)
			ile_pkg::WR_DATA_END: begin
				wr_addr = AW'(count_q);
				wr_data = req_q.data_in;
			end
			ile_pkg::WR_DATA_POS: begin
				wr_addr = AW'(req_q.position);
				wr_data = req_q.data_in;
			end
			ile_pkg::WR_UP: wr_addr = raddr_s1 + AW'(1);
			ile_pkg::WR_DOWN: wr_addr = raddr_s1 - AW'(1);
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem[addr_q];
			raddr_s1 <= addr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			req_q <= req;
		end
		case (cmd.addr_op)
			ile_pkg::ADDR_LAST: addr_q <= AW'(count_q - CW'(1));
			ile_pkg::ADDR_POS: addr_q <= AW'(req_q.position);
			ile_pkg::ADDR_INC: addr_q <= addr_q + AW'(1);
			ile_pkg::ADDR_DEC: addr_q <= addr_q - AW'(1);
			default: addr_q <= addr_q;
		endcase
		case (cmd.res_op)
			ile_pkg::RES_CLR: res_data_q <= '0;
			ile_pkg::RES_TAKE: res_data_q <= rdata_s1;
			default: res_data_q <= res_data_q;
		endcase
		if (cmd.st_set) begin
			status_q <= cmd.st_code;
		end
		if (cmd.out_load) begin
			rsp_q.status     <= status_q;
			rsp_q.data_out   <= res_data_q;
			rsp_q.item_count <= cnt_x[ile_pkg::CNT_W-1:0];
			rsp_q.is_empty   <= (count_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rd_valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.rd_en;
			case (cmd.cnt_op)
				ile_pkg::CNT_INC: count_q <= count_q + CW'(1);
				ile_pkg::CNT_DEC: count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ rtl/core/ile_ctrl.sv @@
// Controller of the indexed list engine: sequences checks, shifts and result hand-off.
module ile_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  ile_pkg::ile_status_t sts,
	output ile_pkg::ile_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SH_UP,
		S_SH_UP_END,
		S_INS_PUT,
		S_RM_SCAN,
		S_RM_DRAIN,
		S_RD_ISSUE,
		S_RD_TAKE,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_nxt   = state_q;
		cmd.req_load = 1'b0;
		cmd.addr_op  = ile_pkg::ADDR_HOLD;
		cmd.rd_en    = 1'b0;
		cmd.wr_op    = ile_pkg::WR_NONE;
		cmd.cnt_op   = ile_pkg::CNT_HOLD;
		cmd.res_op   = ile_pkg::RES_HOLD;
		cmd.st_set   = 1'b0;
		cmd.st_code  = ile_pkg::ST_OK;
		cmd.out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.req_load = 1'b1;
					state_nxt    = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.res_op = ile_pkg::RES_CLR;
				cmd.st_set = 1'b1;
				state_nxt  = S_FINISH;
				case (sts.kind)
					ile_pkg::REQ_APPEND: begin
						if (sts.full) begin
							cmd.st_code = ile_pkg::ST_FULL;
						end else begin
							cmd.wr_op  = ile_pkg::WR_DATA_END;
							cmd.cnt_op = ile_pkg::CNT_INC;
						end
					end
					ile_pkg::REQ_INSERT: begin
						if (sts.pos_gt_count) begin
							cmd.st_code = ile_pkg::ST_BOUNDS;
						end else if (sts.full) begin
							cmd.st_code = ile_pkg::ST_FULL;
						end else if (sts.pos_ge_count) begin
							cmd.wr_op  = ile_pkg::WR_DATA_END;
							cmd.cnt_op = ile_pkg::CNT_INC;
						end else begin
							cmd.addr_op = ile_pkg::ADDR_LAST;
							state_nxt   = S_SH_UP;
						end
					end
					ile_pkg::REQ_REMOVE: begin
						if (sts.pos_ge_count) begin
							cmd.st_code = ile_pkg::ST_BOUNDS;
						end else begin
							cmd.addr_op = ile_pkg::ADDR_POS;
							state_nxt   = S_RM_SCAN;
						end
					end
					default: begin
						if (sts.empty) begin
							cmd.st_code = ile_pkg::ST_EMPTY;
						end else if (sts.pos_ge_count) begin
							cmd.st_code = ile_pkg::ST_BOUNDS;
						end else begin
							cmd.addr_op = ile_pkg::ADDR_POS;
							state_nxt   = S_RD_ISSUE;
						end
					end
				endcase
			end
			S_SH_UP: begin
				cmd.rd_en = 1'b1;
				if (sts.rd_valid_s1) begin
					cmd.wr_op = ile_pkg::WR_UP;
				end
				if (sts.addr_at_pos) begin
					state_nxt = S_SH_UP_END;
				end else begin
					cmd.addr_op = ile_pkg::ADDR_DEC;
				end
			end
			S_SH_UP_END: begin
				cmd.wr_op = ile_pkg::WR_UP;
				state_nxt = S_INS_PUT;
			end
			S_INS_PUT: begin
				cmd.wr_op  = ile_pkg::WR_DATA_POS;
				cmd.cnt_op = ile_pkg::CNT_INC;
				state_nxt  = S_FINISH;
			end
			S_RM_SCAN: begin
				cmd.rd_en = 1'b1;
				if (sts.rd_valid_s1) begin
					if (sts.rd_at_pos_s1) begin
						cmd.res_op = ile_pkg::RES_TAKE;
					end else begin
						cmd.wr_op = ile_pkg::WR_DOWN;
					end
				end
				if (sts.addr_at_last) begin
					state_nxt = S_RM_DRAIN;
				end else begin
					cmd.addr_op = ile_pkg::ADDR_INC;
				end
			end
			S_RM_DRAIN: begin
				if (sts.rd_at_pos_s1) begin
					cmd.res_op = ile_pkg::RES_TAKE;
				end else begin
					cmd.wr_op = ile_pkg::WR_DOWN;
				end
				cmd.cnt_op = ile_pkg::CNT_DEC;
				state_nxt  = S_FINISH;
			end
			S_RD_ISSUE: begin
				cmd.rd_en = 1'b1;
				state_nxt = S_RD_TAKE;
			end
			S_RD_TAKE: begin
				cmd.res_op = ile_pkg::RES_TAKE;
				state_nxt  = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

@@ rtl/core/indexed_list_engine.sv @@
// Top level of the indexed list engine: ordered list with append, insert, remove and read.
// One request is in work at a time, so a new request is accepted only once the
// last one is through. Shifts move one entry per cycle through the store's single
// read and write port.
// Reset clears the count and control state at once; store contents need no clearing pass.
module indexed_list_engine #(
	parameter int CAPACITY = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ile_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ile_pkg::rsp_t rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);

	ile_pkg::ile_cmd_t    cmd;
	ile_pkg::ile_status_t sts;

	ile_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ile_datapath #(
		.CAPACITY (CAPACITY),
		.CW       (CW),
		.AW       (AW)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
